/* hw/rtl/mer_pkg.sv */
// Shared constants and controller/datapath command and status types for the ellipse rasterizer.
package mer_pkg;

    localparam int C_COORD_BITS  = 12;
    localparam int C_RADIUS_BITS = 11;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef enum logic [2:0] {
        MS_RXRX,
        MS_RYRY,
        MS_RX2RY,
        MS_TT,
        MS_YM1SQ,
        MS_RX2_PROD,
        MS_RY2_TMP,
        MS_RX2RY2
    } t_mul_sel;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_STORE_RX2,
        DP_STORE_RY2,
        DP_INIT_R1,
        DP_STORE_TT,
        DP_D_LOAD4,
        DP_D_ADD,
        DP_D_SUB4,
        DP_UPD_R1,
        DP_UPD_R2
    } t_dp_op;

    typedef struct packed {
        logic       latch;
        t_mul_sel   mul_sel;
        t_dp_op     op;
        logic       load_pix;
        logic [1:0] pix_idx;
        logic       load_fin;
    } t_cmd;

    typedef struct packed {
        logic sx_lt_sy;
        logic y_neg;
        logic out_free;
    } t_status;

endpackage

/* hw/rtl/mer_if.sv */
// Request channel interfaces for the ellipse rasterizer input and output.
interface mer_in_if import mer_pkg::*; #(
    parameter int COORD_BITS  = C_COORD_BITS,
    parameter int RADIUS_BITS = C_RADIUS_BITS
);
    logic                   valid;
    logic                   ready;
    logic                   operation;
    logic [COORD_BITS-1:0]  center_x;
    logic [COORD_BITS-1:0]  center_y;
    logic [RADIUS_BITS-1:0] radius_x;
    logic [RADIUS_BITS-1:0] radius_y;

    modport source (
        output valid, operation, center_x, center_y, radius_x, radius_y,
        input  ready
    );
    modport sink (
        input  valid, operation, center_x, center_y, radius_x, radius_y,
        output ready
    );
endinterface

interface mer_out_if import mer_pkg::*; #(
    parameter int COORD_BITS = C_COORD_BITS
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS+1:0] pixel_x;
    logic signed [COORD_BITS+1:0] pixel_y;
    logic                         pixel_valid;
    logic                         last_of_point;
    logic                         finished;

    modport source (
        output valid, pixel_x, pixel_y, pixel_valid, last_of_point, finished,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_valid, last_of_point, finished,
        output ready
    );
endinterface

/* hw/rtl/midpoint_ellipse_rasterizer_top.sv */
// Top level of the midpoint ellipse rasterizer: controller, datapath and channel wiring.
//
//   Channel   Dir   Request payload
//   i_in      in    operation, center_x, center_y, radius_x, radius_y
//   o_out     out   pixel_x, pixel_y, pixel_valid, last_of_point, finished
//
// A start request is accepted, then uses the shared multiplier in states S_M0 to S_M3.
// A step request is accepted and evaluated in S_EVAL, then loads four pixels in S_EMIT;
// the step that crosses into region 2 first runs S_SW0 to S_SW5, mostly on the shared
// multiplier, and a second evaluation. A finished result is loaded in S_FIN.
// Reset is synchronous and returns the block to idle with no ellipse drawn.
// A stalled output holds the pixel sequence; a new request is taken only when idle.
module midpoint_ellipse_rasterizer_top import mer_pkg::*; #(
    parameter int COORD_BITS  = C_COORD_BITS,
    parameter int RADIUS_BITS = C_RADIUS_BITS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    mer_in_if.sink  i_in,
    mer_out_if.source o_out
);

    t_cmd                  w_cmd;
    t_status               w_status;
    logic [COORD_BITS+1:0] w_px, w_py;

    mer_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_op    (i_in.operation),
        .o_in_ready (i_in.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    mer_dp #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_center_x      (i_in.center_x),
        .i_center_y      (i_in.center_y),
        .i_radius_x      (i_in.radius_x),
        .i_radius_y      (i_in.radius_y),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_pixel_x       (w_px),
        .o_pixel_y       (w_py),
        .o_pixel_valid   (o_out.pixel_valid),
        .o_last_of_point (o_out.last_of_point),
        .o_finished      (o_out.finished)
    );

    assign o_out.pixel_x = $signed(w_px);
    assign o_out.pixel_y = $signed(w_py);

`ifndef ASSERT_OFF
    a_no_load_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !(w_cmd.load_pix || w_cmd.load_fin))
        else $error("result loaded while a request could be accepted");

    a_single_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.load_pix && w_cmd.load_fin))
        else $error("pixel and finished result loaded together");

    a_fin_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_fin |=> (o_out.valid && o_out.finished && o_out.last_of_point))
        else $error("finished result not presented");

    a_last_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.load_pix && (&w_cmd.pix_idx)) |=> (o_out.valid && o_out.last_of_point))
        else $error("fourth pixel not marked last");
`endif

endmodule

/* hw/rtl/mer_dp.sv */
// Datapath: latched ellipse, shared multiplier, decision terms, point and output register.
module mer_dp import mer_pkg::*; #(
    parameter int COORD_BITS  = C_COORD_BITS,
    parameter int RADIUS_BITS = C_RADIUS_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    input  logic [COORD_BITS-1:0]   i_center_x,
    input  logic [COORD_BITS-1:0]   i_center_y,
    input  logic [RADIUS_BITS-1:0]  i_radius_x,
    input  logic [RADIUS_BITS-1:0]  i_radius_y,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic [COORD_BITS+1:0]   o_pixel_x,
    output logic [COORD_BITS+1:0]   o_pixel_y,
    output logic                    o_pixel_valid,
    output logic                    o_last_of_point,
    output logic                    o_finished
);

    localparam int P_W  = COORD_BITS + 2;
    localparam int X_W  = RADIUS_BITS + 1;
    localparam int Y_W  = RADIUS_BITS + 2;
    localparam int SQ_W = 2 * RADIUS_BITS;
    localparam int M_W  = 2 * RADIUS_BITS + 4;
    localparam int D_W  = 4 * RADIUS_BITS + 4;

    logic [COORD_BITS-1:0]  r_cx, r_cy;
    logic [RADIUS_BITS-1:0] r_rx, r_ry;
    logic [SQ_W-1:0]        r_rx2, r_ry2;
    logic [D_W-1:0]         r_prod;
    logic [M_W-1:0]         r_tmp;
    logic [D_W-1:0]         r_d, r_sx, r_sy;
    logic [X_W-1:0]         r_x;
    logic [Y_W-1:0]         r_y;

    logic                   r_out_valid;
    logic [P_W-1:0]         r_px, r_py;
    logic                   r_pvalid, r_last, r_fin;

    logic [M_W-1:0]         w_mul_a, w_mul_b;
    logic [2*M_W-1:0]       w_prod_full;
    logic [X_W:0]           w_t;
    logic [Y_W-1:0]         w_ym1;
    logic [D_W-1:0]         w_sx_new, w_sy_new, w_rx2_e, w_ry2_e;
    logic                   w_d_neg, w_d_zero;
    logic [P_W-1:0]         w_xe, w_ye, w_cxe, w_cye;
    logic                   w_out_free;

    assign w_t     = {r_x, 1'b1};
    assign w_ym1   = (r_y == '0) ? Y_W'(1) : (r_y - Y_W'(1));
    assign w_rx2_e = D_W'(r_rx2);
    assign w_ry2_e = D_W'(r_ry2);

    always_comb begin
        unique case (i_cmd.mul_sel)
            MS_RXRX: begin
                w_mul_a = M_W'(r_rx);
                w_mul_b = M_W'(r_rx);
            end
            MS_RYRY: begin
                w_mul_a = M_W'(r_ry);
                w_mul_b = M_W'(r_ry);
            end
            MS_RX2RY: begin
                w_mul_a = M_W'(r_rx2);
                w_mul_b = M_W'(r_ry);
            end
            MS_TT: begin
                w_mul_a = M_W'(w_t);
                w_mul_b = M_W'(w_t);
            end
            MS_YM1SQ: begin
                w_mul_a = M_W'(w_ym1);
                w_mul_b = M_W'(w_ym1);
            end
            MS_RX2_PROD: begin
                w_mul_a = M_W'(r_rx2);
                w_mul_b = r_prod[M_W-1:0];
            end
            MS_RY2_TMP: begin
                w_mul_a = M_W'(r_ry2);
                w_mul_b = r_tmp;
            end
            MS_RX2RY2: begin
                w_mul_a = M_W'(r_rx2);
                w_mul_b = M_W'(r_ry2);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod_full = w_mul_a * w_mul_b;

    assign w_sx_new = r_sx + (w_ry2_e << 1);
    assign w_sy_new = r_sy - (w_rx2_e << 1);
    assign w_d_neg  = r_d[D_W-1];
    assign w_d_zero = (r_d == '0);

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod_full[D_W-1:0];
        if (i_cmd.latch) begin
            r_cx <= i_center_x;
            r_cy <= i_center_y;
            r_rx <= i_radius_x;
            r_ry <= i_radius_y;
        end
        unique case (i_cmd.op)
            DP_NOP: begin
            end
            DP_STORE_RX2: r_rx2 <= r_prod[SQ_W-1:0];
            DP_STORE_RY2: r_ry2 <= r_prod[SQ_W-1:0];
            DP_INIT_R1: begin
                r_d  <= (w_ry2_e << 2) - (r_prod << 2) + w_rx2_e;
                r_sx <= '0;
                r_sy <= r_prod << 1;
                r_x  <= '0;
                r_y  <= Y_W'(r_ry);
            end
            DP_STORE_TT:  r_tmp <= r_prod[M_W-1:0];
            DP_D_LOAD4:   r_d <= r_prod << 2;
            DP_D_ADD:     r_d <= r_d + r_prod;
            DP_D_SUB4:    r_d <= r_d - (r_prod << 2);
            DP_UPD_R1: begin
                r_x  <= r_x + X_W'(1);
                r_sx <= w_sx_new;
                if (w_d_neg) begin
                    r_d <= r_d + ((w_sx_new + w_ry2_e) << 2);
                end else begin
                    r_y  <= r_y - Y_W'(1);
                    r_sy <= w_sy_new;
                    r_d  <= r_d + ((w_sx_new - w_sy_new + w_ry2_e) << 2);
                end
            end
            DP_UPD_R2: begin
                r_y  <= r_y - Y_W'(1);
                r_sy <= w_sy_new;
                if (!w_d_neg && !w_d_zero) begin
                    r_d <= r_d + ((w_rx2_e - w_sy_new) << 2);
                end else begin
                    r_x  <= r_x + X_W'(1);
                    r_sx <= w_sx_new;
                    r_d  <= r_d + ((w_sx_new - w_sy_new + w_rx2_e) << 2);
                end
            end
            default: begin
            end
        endcase
    end

    assign w_xe  = P_W'(r_x);
    assign w_ye  = P_W'($signed(r_y));
    assign w_cxe = P_W'(r_cx);
    assign w_cye = P_W'(r_cy);

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_pix || i_cmd.load_fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pix) begin
            r_px     <= i_cmd.pix_idx[0] ? (w_cxe - w_xe) : (w_cxe + w_xe);
            r_py     <= i_cmd.pix_idx[1] ? (w_cye - w_ye) : (w_cye + w_ye);
            r_pvalid <= 1'b1;
            r_last   <= &i_cmd.pix_idx;
            r_fin    <= 1'b0;
        end else if (i_cmd.load_fin) begin
            r_px     <= '0;
            r_py     <= '0;
            r_pvalid <= 1'b0;
            r_last   <= 1'b1;
            r_fin    <= 1'b1;
        end
    end

    assign o_status.sx_lt_sy = (r_sx < r_sy);
    assign o_status.y_neg    = r_y[Y_W-1];
    assign o_status.out_free = w_out_free;

    assign o_out_valid     = r_out_valid;
    assign o_pixel_x       = r_px;
    assign o_pixel_y       = r_py;
    assign o_pixel_valid   = r_pvalid;
    assign o_last_of_point = r_last;
    assign o_finished      = r_fin;

endmodule

/* hw/rtl/mer_ctrl.sv */
// Controller: request intake, multiplier sequencing, region tracking and pixel emission.
module mer_ctrl import mer_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_op,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_R1   = 4'b0010,
        PH_R2   = 4'b0100,
        PH_DONE = 4'b1000
    } t_phase;

    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_M0   = 15'b000000000000010,
        S_M1   = 15'b000000000000100,
        S_M2   = 15'b000000000001000,
        S_M3   = 15'b000000000010000,
        S_EVAL = 15'b000000000100000,
        S_SW0  = 15'b000000001000000,
        S_SW1  = 15'b000000010000000,
        S_SW2  = 15'b000000100000000,
        S_SW3  = 15'b000001000000000,
        S_SW4  = 15'b000010000000000,
        S_SW5  = 15'b000100000000000,
        S_FIN  = 15'b001000000000000,
        S_EMIT = 15'b010000000000000,
        S_SPARE = 15'b100000000000000
    } t_state;

    t_state     r_state, n_state;
    t_phase     r_phase, n_phase;
    logic [1:0] r_k, n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_phase        = r_phase;
        n_k            = r_k;
        o_in_ready     = 1'b0;
        o_cmd.latch    = 1'b0;
        o_cmd.mul_sel  = MS_RXRX;
        o_cmd.op       = DP_NOP;
        o_cmd.load_pix = 1'b0;
        o_cmd.pix_idx  = r_k;
        o_cmd.load_fin = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_op == OP_START) begin
                        o_cmd.latch = 1'b1;
                        n_state     = S_M0;
                    end else begin
                        n_state = S_EVAL;
                    end
                end
            end
            S_M0: begin
                o_cmd.mul_sel = MS_RXRX;
                n_state       = S_M1;
            end
            S_M1: begin
                o_cmd.mul_sel = MS_RYRY;
                o_cmd.op      = DP_STORE_RX2;
                n_state       = S_M2;
            end
            S_M2: begin
                o_cmd.mul_sel = MS_RX2RY;
                o_cmd.op      = DP_STORE_RY2;
                n_state       = S_M3;
            end
            S_M3: begin
                o_cmd.op = DP_INIT_R1;
                n_phase  = PH_R1;
                n_state  = S_IDLE;
            end
            S_EVAL: begin
                priority if (r_phase == PH_R1 && !i_status.sx_lt_sy) begin
                    n_state = S_SW0;
                end else if (r_phase == PH_R2 && i_status.y_neg) begin
                    n_phase = PH_DONE;
                    n_state = S_FIN;
                end else if (r_phase == PH_IDLE || r_phase == PH_DONE) begin
                    n_state = S_FIN;
                end else begin
                    n_k     = '0;
                    n_state = S_EMIT;
                end
            end
            S_SW0: begin
                o_cmd.mul_sel = MS_TT;
                n_state       = S_SW1;
            end
            S_SW1: begin
                o_cmd.mul_sel = MS_YM1SQ;
                o_cmd.op      = DP_STORE_TT;
                n_state       = S_SW2;
            end
            S_SW2: begin
                o_cmd.mul_sel = MS_RX2_PROD;
                n_state       = S_SW3;
            end
            S_SW3: begin
                o_cmd.mul_sel = MS_RY2_TMP;
                o_cmd.op      = DP_D_LOAD4;
                n_state       = S_SW4;
            end
            S_SW4: begin
                o_cmd.mul_sel = MS_RX2RY2;
                o_cmd.op      = DP_D_ADD;
                n_state       = S_SW5;
            end
            S_SW5: begin
                o_cmd.op = DP_D_SUB4;
                n_phase  = PH_R2;
                n_state  = S_EVAL;
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.load_fin = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.load_pix = 1'b1;
                    n_k            = r_k + 2'd1;
                    if (&r_k) begin
                        o_cmd.op = (r_phase == PH_R1) ? DP_UPD_R1 : DP_UPD_R2;
                        n_state  = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the midpoint ellipse rasterizer against a predictor.
module testbench import mer_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIX_BITS    = C_COORD_BITS + 2;
    localparam int TOTAL_ITEMS = 310;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 20;
    localparam int MAX_REPORTS = 50;

    typedef enum logic [1:0] {
        TRACE_IDLE,
        TRACE_UPPER,
        TRACE_LOWER,
        TRACE_DONE
    } t_trace_phase;

    typedef struct packed {
        logic signed [PIX_BITS-1:0] pixel_x;
        logic signed [PIX_BITS-1:0] pixel_y;
        logic                       pixel_valid;
        logic                       last_of_point;
        logic                       finished;
    } t_pixel_rec;

    class t_ellipse_scoreboard;
        t_trace_phase phase;
        bit [63:0]    pt_x;
        longint       pt_y;
        bit [63:0]    dec;
        bit [63:0]    sx_term;
        bit [63:0]    sy_term;
        bit [63:0]    org_x;
        bit [63:0]    org_y;
        bit [63:0]    rad_x;
        bit [63:0]    rad_y;
        t_pixel_rec   pending_pixels[$];
        int           error_count;

        function new();
            phase = TRACE_IDLE;
            pt_x = '0;
            pt_y = 0;
            dec = '0;
            sx_term = '0;
            sy_term = '0;
            org_x = '0;
            org_y = '0;
            rad_x = '0;
            rad_y = '0;
            error_count = 0;
        endfunction

        function void refresh_terms();
            sx_term = 2 * rad_y * rad_y * pt_x;
            sy_term = 2 * rad_x * rad_x * pt_y;
        endfunction

        function void push_pixel(bit [63:0] px, bit [63:0] py, bit pv, bit lp, bit fin);
            t_pixel_rec rec;
            rec.pixel_x = px[PIX_BITS-1:0];
            rec.pixel_y = py[PIX_BITS-1:0];
            rec.pixel_valid = pv;
            rec.last_of_point = lp;
            rec.finished = fin;
            pending_pixels.push_back(rec);
        endfunction

        function void note_request(logic op, logic [C_COORD_BITS-1:0] cx,
                                   logic [C_COORD_BITS-1:0] cy,
                                   logic [C_RADIUS_BITS-1:0] rx,
                                   logic [C_RADIUS_BITS-1:0] ry);
            bit [63:0] rx2;
            bit [63:0] ry2;
            bit [63:0] t;
            bit [63:0] ym1;
            bit [63:0] y64;
            if (op == OP_START) begin
                org_x = 64'(cx);
                org_y = 64'(cy);
                rad_x = 64'(rx);
                rad_y = 64'(ry);
                rx2 = rad_x * rad_x;
                ry2 = rad_y * rad_y;
                pt_x = '0;
                pt_y = longint'(rad_y);
                refresh_terms();
                dec = 4 * ry2 - 4 * rx2 * rad_y + rx2;
                phase = TRACE_UPPER;
                return;
            end
            rx2 = rad_x * rad_x;
            ry2 = rad_y * rad_y;
            if (phase == TRACE_UPPER && !(sx_term < sy_term)) begin
                t = 2 * pt_x + 1;
                ym1 = pt_y - 1;
                dec = ry2 * t * t + 4 * rx2 * ym1 * ym1 - 4 * rx2 * ry2;
                phase = TRACE_LOWER;
            end
            if (phase == TRACE_LOWER && pt_y < 0)
                phase = TRACE_DONE;
            if (phase == TRACE_IDLE || phase == TRACE_DONE) begin
                push_pixel('0, '0, 1'b0, 1'b1, 1'b1);
                return;
            end
            y64 = pt_y;
            push_pixel(org_x + pt_x, org_y + y64, 1'b1, 1'b0, 1'b0);
            push_pixel(org_x - pt_x, org_y + y64, 1'b1, 1'b0, 1'b0);
            push_pixel(org_x + pt_x, org_y - y64, 1'b1, 1'b0, 1'b0);
            push_pixel(org_x - pt_x, org_y - y64, 1'b1, 1'b1, 1'b0);
            if (phase == TRACE_UPPER) begin
                pt_x = pt_x + 1;
                if (dec[63]) begin
                    refresh_terms();
                    dec = dec + 4 * (sx_term + ry2);
                end else begin
                    pt_y = pt_y - 1;
                    refresh_terms();
                    dec = dec + 4 * (sx_term - sy_term + ry2);
                end
            end else begin
                pt_y = pt_y - 1;
                if (!dec[63] && dec != 0) begin
                    refresh_terms();
                    dec = dec + 4 * (rx2 - sy_term);
                end else begin
                    pt_x = pt_x + 1;
                    refresh_terms();
                    dec = dec + 4 * (sx_term - sy_term + rx2);
                end
            end
        endfunction

        function void check_result(logic signed [PIX_BITS-1:0] px,
                                   logic signed [PIX_BITS-1:0] py,
                                   logic pv, logic lp, logic fin);
            t_pixel_rec got;
            t_pixel_rec want;
            got.pixel_x = px;
            got.pixel_y = py;
            got.pixel_valid = pv;
            got.last_of_point = lp;
            got.finished = fin;
            if (pending_pixels.size() == 0) begin
                if (error_count < MAX_REPORTS)
                    $display("%0t: unexpected result x=%0d y=%0d valid=%0b last=%0b fin=%0b",
                             $time, px, py, pv, lp, fin);
                error_count++;
                return;
            end
            want = pending_pixels.pop_front();
            if (got !== want) begin
                if (error_count < MAX_REPORTS)
                    $display("%0t: mismatch expected x=%0d y=%0d valid=%0b last=%0b fin=%0b,",
                             $time, want.pixel_x, want.pixel_y, want.pixel_valid,
                             want.last_of_point, want.finished,
                             " actual x=%0d y=%0d valid=%0b last=%0b fin=%0b",
                             px, py, pv, lp, fin);
                error_count++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   calm;
    int   sent;

    t_ellipse_scoreboard sb;

    mer_in_if  in_ch ();
    mer_out_if out_ch ();

    midpoint_ellipse_rasterizer_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #6 i_clk = ~i_clk;

    task automatic send_request(input logic op, input logic [C_COORD_BITS-1:0] cx,
                                input logic [C_COORD_BITS-1:0] cy,
                                input logic [C_RADIUS_BITS-1:0] rx,
                                input logic [C_RADIUS_BITS-1:0] ry);
        while (!calm && $urandom_range(99) < 38) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.center_x  <= cx;
        in_ch.center_y  <= cy;
        in_ch.radius_x  <= rx;
        in_ch.radius_y  <= ry;
        do
            @(posedge i_clk);
        while (!(in_ch.valid === 1'b1 && in_ch.ready === 1'b1));
        sb.note_request(op, cx, cy, rx, ry);
        sent++;
    endtask

    task automatic start_ellipse(input int cx, input int cy, input int rx, input int ry);
        send_request(OP_START, C_COORD_BITS'(cx), C_COORD_BITS'(cy),
                     C_RADIUS_BITS'(rx), C_RADIUS_BITS'(ry));
    endtask

    task automatic advance(input int count);
        repeat (count)
            send_request(OP_STEP, C_COORD_BITS'($urandom_range(4095)),
                         C_COORD_BITS'($urandom_range(4095)),
                         C_RADIUS_BITS'($urandom_range(2047)),
                         C_RADIUS_BITS'($urandom_range(2047)));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            sb.check_result(out_ch.pixel_x, out_ch.pixel_y, out_ch.pixel_valid,
                            out_ch.last_of_point, out_ch.finished);
        out_ch.ready <= calm || ($urandom_range(99) >= 38);
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        int  kind;
        int  rx;
        int  ry;
        int  steps;
        bit  paused;
        sb = new();
        calm = 1'b0;
        sent = 0;
        paused = 1'b0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_START;
        in_ch.center_x = '0;
        in_ch.center_y = '0;
        in_ch.radius_x = '0;
        in_ch.radius_y = '0;
        out_ch.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        advance(1);
        start_ellipse(0, 0, 0, 0);
        advance(3);
        start_ellipse(4095, 4095, 2047, 2047);
        advance(2);
        start_ellipse(0, 0, 2047, 0);
        advance(2);
        start_ellipse(0, 0, 0, 2047);
        advance(1);
        start_ellipse(2, 1, 3, 2);
        advance(8);

        while (sent < TOTAL_ITEMS) begin
            if (!paused && sent >= 160) begin
                // Hold the input back until the block has delivered everything.
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
                while (sb.pending_pixels.size() != 0)
                    @(posedge i_clk);
                paused = 1'b1;
            end
            calm = (sent >= 90 && sent < 150);
            kind = $urandom_range(99);
            if (kind < 85) begin
                if ($urandom_range(9) == 0) begin
                    rx = $urandom_range(2047);
                    ry = $urandom_range(2047);
                    steps = $urandom_range(8, 2);
                end else begin
                    rx = $urandom_range(12);
                    ry = $urandom_range(12);
                    steps = rx + ry + $urandom_range(4, 1);
                end
                start_ellipse($urandom_range(4095), $urandom_range(4095), rx, ry);
                advance(steps);
            end else if (kind < 93) begin
                start_ellipse($urandom_range(4095), $urandom_range(4095),
                              $urandom_range(12), $urandom_range(12));
                advance($urandom_range(3));
            end else begin
                advance($urandom_range(3, 1));
            end
        end
        calm = 1'b0;

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/mer_pkg.sv
hw/rtl/mer_if.sv
hw/rtl/mer_dp.sv
hw/rtl/mer_ctrl.sv
hw/rtl/midpoint_ellipse_rasterizer_top.sv
bench/testbench.sv
